### hdl/ean8px_pkg.sv
// ----------------------------------------------------------------------------
// ean8px_pkg
// Types and constants shared by the EAN-8 pixel raster block.
// ----------------------------------------------------------------------------
`default_nettype none

package ean8px_pkg;

  localparam int unsigned ColW    = 11;
  localparam int unsigned RowW    = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned ModuleCount = 67;
  localparam int unsigned ModIdxW     = 7;

  // register indexes on the write port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIGITS = 2'd0,
    CFG_MARGIN = 2'd1,
    CFG_MWIDTH = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_idx_e;

  // reset values of the registers
  localparam logic [31:0] DigitsRst = 32'h0000_0000;
  localparam logic [7:0]  MarginRst = 8'd4;
  localparam logic [4:0]  MwidthRst = 5'd3;
  localparam logic [9:0]  HeightRst = 10'd50;

  // L-code (odd parity) patterns, MSB is the leftmost module
  localparam logic [6:0] LPatterns [10] = '{
    7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
  };

  typedef struct packed {
    logic [ColW-1:0] pixel_col;
    logic [RowW-1:0] pixel_row;
  } pix_in_t;

  typedef struct packed {
    logic pixel_black;
    logic id_valid;
    logic inside_image;
  } pix_out_t;

endpackage : ean8px_pkg

`default_nettype wire

### hdl/ean8_barcode_pixel_raster.sv
// ----------------------------------------------------------------------------
// ean8_barcode_pixel_raster
// Per-pixel lookup of an EAN-8 barcode image with quiet margin.
// ----------------------------------------------------------------------------
// One pixel word is taken on every clock in which start is high; busy stays
// low, so the block never holds off a request. The result appears on res_o
// with res_valid_o high, one result per request, in request order. The request is
// captured, then goes through the column-to-module division, a restoring divider
// split over two register stages, followed by a stage for the module pattern lookup.
// The receiver cannot stall the output.
// Register writes take effect for requests started on the following clock.
`default_nettype none

module ean8_barcode_pixel_raster
  import ean8px_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request
  input  wire logic                start,
  output      logic                busy,
  input  wire pix_in_t             pix_i,
  // result
  output      logic                res_valid_o,
  output      pix_out_t            res_o,
  // register write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned WideW = 12;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  logic [31:0] digits_q;
  logic [7:0]  margin_q;
  logic [4:0]  mwidth_q;
  logic [9:0]  height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= DigitsRst;
      margin_q <= MarginRst;
      mwidth_q <= MwidthRst;
      height_q <= HeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIGITS: digits_q <= cfg_wdata_i;
        CFG_MARGIN: margin_q <= cfg_wdata_i[7:0];
        CFG_MWIDTH: mwidth_q <= cfg_wdata_i[4:0];
        CFG_HEIGHT: height_q <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // values derived from the registers, registered behind them
  // --------------------------------------------------------------------------
  logic [4:0]        mw_d, mw_q;
  logic [WideW-1:0]  code_w;
  logic [WideW-1:0]  code_end_d, code_end_q;
  logic [WideW-1:0]  total_w_d, total_w_q;
  logic [RowW-1:0]   bar_end_d, bar_end_q;
  logic [RowW-1:0]   total_h_d, total_h_q;
  logic [7:0]        sum_d, sum_q;
  logic              dec_d, dec_q;
  logic [3:0]        chk_q;
  logic              id_ok_d, id_ok_q;
  logic [3:0]        dg [8];

  localparam logic [4:0] MwRst = (MwidthRst == 5'd0) ? 5'd1 : MwidthRst;
  localparam logic [WideW-1:0] CodeWRst = WideW'(ModuleCount * MwRst);

  function automatic logic [3:0] mod10(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (r >= 8'd160) r = r - 8'd160;
    if (r >= 8'd80)  r = r - 8'd80;
    if (r >= 8'd40)  r = r - 8'd40;
    if (r >= 8'd20)  r = r - 8'd20;
    if (r >= 8'd10)  r = r - 8'd10;
    return r[3:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      dg[i] = digits_q[31 - 4*i -: 4];
    end
    mw_d       = (mwidth_q == 5'd0) ? 5'd1 : mwidth_q;
    code_w     = WideW'(ModuleCount) * WideW'(mw_d);
    code_end_d = code_w + WideW'(margin_q);
    total_w_d  = code_w + {3'b000, margin_q, 1'b0};
    bar_end_d  = RowW'(height_q) + RowW'(margin_q);
    total_h_d  = RowW'(height_q) + {2'b00, margin_q, 1'b0};
    sum_d      = 8'(3 * ({4'h0, dg[0]} + {4'h0, dg[2]} + {4'h0, dg[4]} + {4'h0, dg[6]}))
               + {4'h0, dg[1]} + {4'h0, dg[3]} + {4'h0, dg[5]};
    dec_d      = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (dg[i] > 4'd9) dec_d = 1'b0;
    end
  end

  // check digit compare is registered again behind the registered sum
  always_comb begin
    logic [3:0] r;
    logic [3:0] expect_chk;
    r          = mod10(sum_q);
    expect_chk = (r == 4'd0) ? 4'd0 : 4'd10 - r;
    id_ok_d    = dec_q && (expect_chk == chk_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mw_q       <= MwRst;
      code_end_q <= CodeWRst + WideW'(MarginRst);
      total_w_q  <= CodeWRst + WideW'(2 * MarginRst);
      bar_end_q  <= RowW'(HeightRst) + RowW'(MarginRst);
      total_h_q  <= RowW'(HeightRst) + RowW'(2 * MarginRst);
      sum_q      <= 8'd0;
      dec_q      <= 1'b1;
      chk_q      <= 4'd0;
      id_ok_q    <= 1'b1;
    end else begin
      mw_q       <= mw_d;
      code_end_q <= code_end_d;
      total_w_q  <= total_w_d;
      bar_end_q  <= bar_end_d;
      total_h_q  <= total_h_d;
      sum_q      <= sum_d;
      dec_q      <= dec_d;
      chk_q      <= dg[7];
      id_ok_q    <= id_ok_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: capture request, offset into the code area
  // --------------------------------------------------------------------------
  logic            accept;
  logic            s1_valid_q;
  logic [ColW-1:0] s1_col_d, s1_col_q;
  logic [RowW-1:0] s1_row_d, s1_row_q;
  logic [ColW-1:0] s1_off_d, s1_off_q;
  logic            s1_ge_d, s1_ge_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    s1_col_d = pix_i.pixel_col;
    s1_row_d = pix_i.pixel_row;
    s1_off_d = pix_i.pixel_col - ColW'(margin_q);
    s1_ge_d  = (pix_i.pixel_col >= ColW'(margin_q)) && (pix_i.pixel_row >= RowW'(margin_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q <= s1_col_d;
      s1_row_q <= s1_row_d;
      s1_off_q <= s1_off_d;
      s1_ge_q  <= s1_ge_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: region compares, divider quotient bits 6..4
  // --------------------------------------------------------------------------
  logic            s2_valid_q;
  logic            s2_code_d, s2_code_q;
  logic            s2_inside_d, s2_inside_q;
  logic [2:0]      s2_qhi_d, s2_qhi_q;
  logic [ColW-1:0] s2_rem_d, s2_rem_q;

  always_comb begin
    logic [WideW-1:0] rem;
    logic [WideW-1:0] dsh;
    s2_inside_d = ({1'b0, s1_col_q} < total_w_q) && (s1_row_q < total_h_q);
    s2_code_d   = s1_ge_q && ({1'b0, s1_col_q} < code_end_q) && (s1_row_q < bar_end_q);
    rem         = {1'b0, s1_off_q};
    s2_qhi_d    = 3'b000;
    for (int k = 0; k < 3; k++) begin
      dsh = WideW'(mw_q) << (6 - k);
      if (rem >= dsh) begin
        rem             = rem - dsh;
        s2_qhi_d[2 - k] = 1'b1;
      end
    end
    s2_rem_d = rem[ColW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_code_q   <= s2_code_d;
      s2_inside_q <= s2_inside_d;
      s2_qhi_q    <= s2_qhi_d;
      s2_rem_q    <= s2_rem_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: divider quotient bits 3..0 -> module index
  // --------------------------------------------------------------------------
  logic               s3_valid_q;
  logic               s3_code_q;
  logic               s3_inside_q;
  logic [ModIdxW-1:0] s3_midx_d, s3_midx_q;

  always_comb begin
    logic [WideW-1:0] rem;
    logic [WideW-1:0] dsh;
    logic [3:0]       qlo;
    rem = {1'b0, s2_rem_q};
    qlo = 4'h0;
    for (int k = 0; k < 4; k++) begin
      dsh = WideW'(mw_q) << (3 - k);
      if (rem >= dsh) begin
        rem        = rem - dsh;
        qlo[3 - k] = 1'b1;
      end
    end
    s3_midx_d = {s2_qhi_q, qlo};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_code_q   <= s2_code_q;
      s3_inside_q <= s2_inside_q;
      s3_midx_q   <= s3_midx_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: module pattern lookup, output register
  // --------------------------------------------------------------------------
  function automatic logic module_bit(input logic [ModIdxW-1:0] m,
                                      input logic [31:0]        digits);
    logic [2:0]         pos;
    logic [ModIdxW-1:0] base;
    logic [2:0]         sub;
    logic [3:0]         d;
    logic [6:0]         pat;
    logic               right;
    logic               b;
    pos   = 3'd0;
    base  = 7'd3;
    right = 1'b0;
    b     = 1'b0;
    if (m < 7'd3) begin
      b = (m == 7'd0) || (m == 7'd2);
    end else if (m >= 7'd64) begin
      b = (m == 7'd64) || (m == 7'd66);
    end else if ((m >= 7'd31) && (m < 7'd36)) begin
      b = (m == 7'd32) || (m == 7'd34);
    end else begin
      if (m < 7'd31) begin
        if (m >= 7'd24)      begin pos = 3'd3; base = 7'd24; end
        else if (m >= 7'd17) begin pos = 3'd2; base = 7'd17; end
        else if (m >= 7'd10) begin pos = 3'd1; base = 7'd10; end
        else                 begin pos = 3'd0; base = 7'd3;  end
      end else begin
        right = 1'b1;
        if (m >= 7'd57)      begin pos = 3'd7; base = 7'd57; end
        else if (m >= 7'd50) begin pos = 3'd6; base = 7'd50; end
        else if (m >= 7'd43) begin pos = 3'd5; base = 7'd43; end
        else                 begin pos = 3'd4; base = 7'd36; end
      end
      sub = 3'(m - base);
      d   = digits[31 - 4*pos -: 4];
      pat = LPatterns[(d < 4'd10) ? d : 4'd0];
      if (right) pat = ~pat;
      b = pat[3'd6 - sub];
    end
    return b;
  endfunction

  logic     res_valid_q;
  pix_out_t res_d, res_q;

  always_comb begin
    res_d.id_valid     = id_ok_q;
    res_d.inside_image = s3_inside_q;
    res_d.pixel_black  = id_ok_q && s3_code_q && module_bit(s3_midx_q, digits_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  // a black pixel only comes from a good identifier inside the image
  a_black_implies_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.pixel_black |-> res_o.id_valid && res_o.inside_image)
    else $error("black pixel with bad identifier or outside image");

  // every word that enters stage 1 leaves through stages 2, 3 and the output register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o == $past(s1_valid_q, 3))
    else $error("result strobe out of step with pipeline");

  // the bar area lies within the image bounds
  a_code_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_code_q |-> s2_inside_q)
    else $error("bar area word flagged outside image");
`endif

endmodule : ean8_barcode_pixel_raster

`default_nettype wire

### tb/sv/ean8_barcode_pixel_raster_tb.sv
// ----------------------------------------------------------------------------
// ean8_barcode_pixel_raster_tb
// Self-checking bench for the EAN-8 pixel raster. Pixel words go in through
// the start/busy port with random idle gaps. Each result is checked against a
// scoreboard that keeps its own copy of the registers and works out the pixel
// color, identifier check and image bounds. Registers are rewritten between
// phases, only once the pipeline is empty, walking margin, module width, bar
// height and the identifier through their extremes and through invalid codes.
// ----------------------------------------------------------------------------

module ean8_barcode_pixel_raster_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ean8px_pkg::*;

  localparam real         ClkPeriod  = 2.0;
  localparam int unsigned CycleLimit = 100000;
  localparam int          NumPhases  = 24;
  localparam int          PhaseItems = 75;

  class pixel_scoreboard;
    logic [31:0] digits;
    logic [7:0]  margin;
    logic [4:0]  mwidth;
    logic [9:0]  height;
    pix_in_t     request_q[$];
    pix_out_t    expected_q[$];
    int          mismatches;

    function new();
      digits     = DigitsRst;
      margin     = MarginRst;
      mwidth     = MwidthRst;
      height     = HeightRst;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_DIGITS: digits = data;
        CFG_MARGIN: margin = data[7:0];
        CFG_MWIDTH: mwidth = data[4:0];
        CFG_HEIGHT: height = data[9:0];
        default: ;
      endcase
    endfunction

    function logic [3:0] digit_at(int pos);
      return digits[31-4*pos -: 4];
    endfunction

    function bit id_ok();
      int sum;
      sum = 0;
      for (int i = 0; i < 8; i++) begin
        if (digit_at(i) > 9) return 1'b0;
      end
      for (int i = 0; i < 7; i++) begin
        sum += (i % 2 == 0) ? 3 * digit_at(i) : digit_at(i);
      end
      return ((10 - sum % 10) % 10) == digit_at(7);
    endfunction

    // one module of the 67: guards are fixed, digit areas are 7 modules each
    function bit module_is_black(int m);
      logic [3:0] d;
      logic [6:0] pat;
      int         sub;
      if (m < 3) return m != 1;
      if (m >= 64) return m != 65;
      if (m >= 31 && m < 36) return m == 32 || m == 34;
      if (m < 31) begin
        d   = digit_at((m - 3) / 7);
        sub = (m - 3) % 7;
        pat = LPatterns[d < 10 ? d : 0];
      end else begin
        d   = digit_at(4 + (m - 36) / 7);
        sub = (m - 36) % 7;
        pat = ~LPatterns[d < 10 ? d : 0];
      end
      return pat[6-sub];
    endfunction

    function pix_out_t predict_pixel(pix_in_t p);
      pix_out_t r;
      int       mw, code_w, total_w, total_h, col, row;
      col     = p.pixel_col;
      row     = p.pixel_row;
      mw      = (mwidth == 0) ? 1 : mwidth;
      code_w  = ModuleCount * mw;
      total_w = code_w + 2 * margin;
      total_h = height + 2 * margin;
      r.id_valid     = id_ok();
      r.inside_image = col < total_w && row < total_h;
      r.pixel_black  = 1'b0;
      if (r.id_valid && r.inside_image && row >= margin && row < margin + height &&
          col >= margin && col < margin + code_w) begin
        r.pixel_black = module_is_black((col - margin) / mw);
      end
      return r;
    endfunction

    function void note_request(pix_in_t p);
      request_q.push_back(p);
      expected_q.push_back(predict_pixel(p));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(pix_out_t got);
      pix_in_t  req;
      pix_out_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("result %b with no request outstanding", got));
        return;
      end
      req = request_q.pop_front();
      exp = expected_q.pop_front();
      if (got.pixel_black !== exp.pixel_black)
        report($sformatf("col %0d row %0d: pixel_black %b, want %b",
                         req.pixel_col, req.pixel_row, got.pixel_black, exp.pixel_black));
      if (got.id_valid !== exp.id_valid)
        report($sformatf("col %0d row %0d: id_valid %b, want %b",
                         req.pixel_col, req.pixel_row, got.id_valid, exp.id_valid));
      if (got.inside_image !== exp.inside_image)
        report($sformatf("col %0d row %0d: inside_image %b, want %b",
                         req.pixel_col, req.pixel_row, got.inside_image,
                         exp.inside_image));
    endtask

    task check_drained();
      if (expected_q.size() != 0)
        report($sformatf("%0d results never came out", expected_q.size()));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  pix_in_t             pix_i;
  logic                res_valid_o;
  pix_out_t            res_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  pixel_scoreboard sb = new();
  int unsigned     cycle_count = 0;

  ean8_barcode_pixel_raster dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pix_i       (pix_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // request noted before the register write: a write affects the next word on
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_request(pix_i);
      if (res_valid_o) sb.check_result(res_o);
      if (cfg_we_i) sb.write_reg(cfg_idx_e'(cfg_idx_i), cfg_wdata_i);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_pixel(input logic [10:0] col, input logic [10:0] row,
                            input bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 23) begin
      @(negedge clk_i);
      start           <= 1'b0;
      pix_i.pixel_col <= 11'($urandom_range(0, 2047));
      pix_i.pixel_row <= 11'($urandom_range(0, 2047));
    end
    @(negedge clk_i);
    start           <= 1'b1;
    pix_i.pixel_col <= col;
    pix_i.pixel_row <= row;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // upper bits of the narrow registers carry junk that must be dropped
  task automatic load_geometry(input int margin, input int mwidth, input int height);
    logic [CfgDataW-1:0] w;
    w = $urandom;
    w[7:0] = 8'(margin);
    write_reg(CFG_MARGIN, w);
    w = $urandom;
    w[4:0] = 5'(mwidth);
    write_reg(CFG_MWIDTH, w);
    w = $urandom;
    w[9:0] = 10'(height);
    write_reg(CFG_HEIGHT, w);
  endtask

  // kind 0: valid code, 1: wrong check digit, 2: non-decimal nibble, 3: raw
  function automatic logic [31:0] make_identifier(int kind);
    logic [31:0] id;
    int          d, sum, chk;
    id  = '0;
    sum = 0;
    for (int i = 0; i < 7; i++) begin
      d   = $urandom_range(0, 9);
      id[31-4*i -: 4] = 4'(d);
      sum += (i % 2 == 0) ? 3 * d : d;
    end
    chk = (10 - sum % 10) % 10;
    id[3:0] = 4'(chk);
    case (kind)
      1: id[3:0] = 4'((chk + $urandom_range(1, 9)) % 10);
      2: id[31-4*$urandom_range(0, 7) -: 4] = 4'($urandom_range(10, 15));
      3: id = $urandom;
      default: ;
    endcase
    return id;
  endfunction

  function automatic int pick_extreme(int lo, int hi, int typ_lo, int typ_hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(typ_lo, typ_hi);
  endfunction

  task automatic load_phase_config(input int ph);
    int margin, mwidth, height, r;
    r = $urandom_range(0, 99);
    write_reg(CFG_DIGITS, make_identifier(r < 70 ? 0 : r < 82 ? 1 : r < 94 ? 2 : 3));
    margin = pick_extreme(0, 255, 0, 12);
    mwidth = pick_extreme(0, 31, 1, 6);
    height = pick_extreme(0, 1023, 1, 80);
    case (ph)
      0: begin margin = 0;   mwidth = 1;  height = 1;    end
      1: begin margin = 255; mwidth = 31; height = 1023; end
      2: begin mwidth = 0;   height = 0;                 end
      3: begin margin = 1;   mwidth = 16;                end
      4: begin margin = 0;   height = 1023;              end
      default: ;
    endcase
    load_geometry(margin, mwidth, height);
  endtask

  // most pixels land in or just around the image, some near its edges
  task automatic send_random_pixel(input bit may_idle);
    int mw, cw, tw, th, m, c, r, sel;
    m   = sb.margin;
    mw  = (sb.mwidth == 0) ? 1 : sb.mwidth;
    cw  = ModuleCount * mw;
    tw  = cw + 2 * m;
    th  = sb.height + 2 * m;
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      c = $urandom_range(0, tw + 1);
      r = $urandom_range(0, th + 1);
    end else if (sel < 85) begin
      case ($urandom_range(0, 5))
        0: c = m - 1;
        1: c = m;
        2: c = m + cw - 1;
        3: c = m + cw;
        4: c = tw - 1;
        default: c = tw;
      endcase
      case ($urandom_range(0, 5))
        0: r = m - 1;
        1: r = m;
        2: r = m + sb.height - 1;
        3: r = m + sb.height;
        4: r = th - 1;
        default: r = th;
      endcase
      c = c + $urandom_range(0, 2) - 1;
      r = r + $urandom_range(0, 2) - 1;
    end else begin
      c = $urandom_range(0, 2047);
      r = $urandom_range(0, 2047);
    end
    if (c < 0 || c > 2047) c = $urandom_range(0, 2047);
    if (r < 0 || r > 2047) r = $urandom_range(0, 2047);
    send_pixel(11'(c), 11'(r), may_idle);
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    pix_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_DIGITS;
    cfg_wdata_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: margin 4, module 3 px, bars 50 rows, all-zero code
    send_pixel(0, 0, 1'b0);
    send_pixel(3, 4, 1'b0);
    send_pixel(4, 3, 1'b0);
    send_pixel(4, 4, 1'b0);
    send_pixel(7, 4, 1'b0);
    send_pixel(204, 53, 1'b0);
    send_pixel(205, 53, 1'b0);
    send_pixel(208, 57, 1'b0);
    send_pixel(209, 57, 1'b0);
    send_pixel(208, 58, 1'b0);
    send_pixel(2047, 2047, 1'b0);
    send_pixel(2047, 0, 1'b0);
    send_pixel(0, 2047, 1'b0);

    // a real code: centre guard, R-coded area, check digit area
    wait_drained();
    write_reg(CFG_DIGITS, 32'h9638_5074);
    send_pixel(97, 20, 1'b0);
    send_pixel(100, 20, 1'b0);
    send_pixel(112, 20, 1'b0);
    send_pixel(184, 20, 1'b0);
    send_pixel(16, 20, 1'b0);

    // bad check digit, then a non-decimal nibble
    wait_drained();
    write_reg(CFG_DIGITS, 32'h9638_5075);
    send_pixel(4, 20, 1'b0);
    send_pixel(300, 20, 1'b0);
    wait_drained();
    write_reg(CFG_DIGITS, 32'hA638_5074);
    send_pixel(4, 20, 1'b0);
    send_pixel(100, 20, 1'b0);

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      load_phase_config(ph);
      for (int i = 0; i < PhaseItems; i++) begin
        // hold off once mid-phase until the pipeline is empty
        if (ph == 5 && i == PhaseItems / 2) wait_drained();
        send_random_pixel(!(ph == 6 || ph == 7));
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    sb.check_drained();
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
